### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked during reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/arpm_pkg.sv
// Package with the widths, codes and shared types of the dead-band mapper.
`default_nettype none

package arpm_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int HYST_BITS     = 8;
  localparam int FULL_BITS     = 10;
  localparam int DUTY_BITS     = FULL_BITS;
  localparam int DIR_BITS      = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 10;
  localparam int DIV_CNT_BITS  = $clog2(FULL_BITS);

  localparam logic [CFG_IDX_BITS-1:0] CFG_DYNAMIC = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HYST    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FULL    = 2'd2;

  localparam logic [FULL_BITS-1:0] FULL_SCALE_RESET = 10'd255;

  typedef enum logic [DIR_BITS-1:0] {
    DIR_DEAD = 2'd0,
    DIR_NEG  = 2'd1,
    DIR_POS  = 2'd2
  } dir_t;

  typedef struct packed {
    dir_t                   dir;
    logic [SAMPLE_BITS-1:0] num;
    logic [SAMPLE_BITS-1:0] den;
  } band_t;

endpackage

`default_nettype wire

### hw/rtl/arpm_if.sv
// Valid/ready channel interfaces for samples and duty results.
`default_nettype none

interface arpm_in_if;
  logic                             valid;
  logic                             ready;
  logic [arpm_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface arpm_out_if;
  logic                           valid;
  logic                           ready;
  logic [arpm_pkg::DIR_BITS-1:0]  direction;
  logic [arpm_pkg::DUTY_BITS-1:0] duty;

  modport source (output valid, output direction, output duty, input ready);
  modport sink   (input valid, input direction, input duty, output ready);
endinterface

`default_nettype wire

### hw/rtl/arpm_range.sv
// Range tracker and dead-band classifier, a four-stage pipeline.
`default_nettype none

module arpm_range (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start_i,
  input  wire logic [arpm_pkg::SAMPLE_BITS-1:0] sample_i,
  input  wire logic                             dynamic_mode_i,
  input  wire logic [arpm_pkg::HYST_BITS-1:0]   hysteresis_i,
  input  wire logic [arpm_pkg::FULL_BITS-1:0]   full_scale_i,
  output arpm_pkg::band_t                       band_o,
  output logic                                  band_valid_o
);

  logic [arpm_pkg::SAMPLE_BITS-1:0] lo_r, hi_r, lo_nxt, hi_nxt;
  logic [arpm_pkg::SAMPLE_BITS-1:0] x1_r, top1_r, bot1_r, top1_nxt, bot1_nxt;
  logic [arpm_pkg::SAMPLE_BITS-1:0] x2_r, top2_r, bot2_r, span2_r, half2_r, span2_nxt;
  logic [arpm_pkg::SAMPLE_BITS-1:0] x3_r, lower3_r, upper3_r, offlo3_r, offhi3_r;
  logic [arpm_pkg::SAMPLE_BITS-1:0] hyst_w, rest_w, offlo_nxt, offhi_nxt;
  logic                             v1_r, v2_r, v3_r, v4_r;
  arpm_pkg::band_t                  band_r, band_nxt;

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (dynamic_mode_i && (sample_i < lo_r)) begin
      lo_nxt = sample_i;
    end
    if (dynamic_mode_i && (sample_i > hi_r)) begin
      hi_nxt = sample_i;
    end
    if (dynamic_mode_i) begin
      top1_nxt = hi_nxt;
      bot1_nxt = lo_nxt;
    end else begin
      top1_nxt = arpm_pkg::SAMPLE_BITS'(full_scale_i);
      bot1_nxt = '0;
    end
  end

  assign span2_nxt = top1_r - bot1_r;

  assign hyst_w    = arpm_pkg::SAMPLE_BITS'(hysteresis_i);
  assign rest_w    = span2_r - half2_r;
  assign offlo_nxt = (half2_r >= hyst_w) ? (half2_r - hyst_w) : '0;
  assign offhi_nxt = (rest_w >= hyst_w) ? (rest_w - hyst_w) : '0;

  always_comb begin
    band_nxt.dir = arpm_pkg::DIR_DEAD;
    band_nxt.num = '0;
    band_nxt.den = '0;
    if (x3_r <= lower3_r) begin
      band_nxt.dir = arpm_pkg::DIR_NEG;
      band_nxt.num = lower3_r - x3_r;
      band_nxt.den = offlo3_r;
    end else if (x3_r >= upper3_r) begin
      band_nxt.dir = arpm_pkg::DIR_POS;
      band_nxt.num = x3_r - upper3_r;
      band_nxt.den = offhi3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '1;
      hi_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (start_i) begin
        lo_r <= lo_nxt;
        hi_r <= hi_nxt;
      end
      v1_r <= start_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    if (start_i) begin
      x1_r   <= sample_i;
      top1_r <= top1_nxt;
      bot1_r <= bot1_nxt;
    end
    x2_r     <= x1_r;
    top2_r   <= top1_r;
    bot2_r   <= bot1_r;
    span2_r  <= span2_nxt;
    half2_r  <= span2_nxt >> 1;
    x3_r     <= x2_r;
    lower3_r <= bot2_r + offlo_nxt;
    upper3_r <= top2_r - offhi_nxt;
    offlo3_r <= offlo_nxt;
    offhi3_r <= offhi_nxt;
    band_r   <= band_nxt;
  end

  assign band_o       = band_r;
  assign band_valid_o = v4_r;

endmodule

`default_nettype wire

### hw/rtl/arpm_div.sv
// Duty scaler: one product, then a bit-serial restoring divider.
`default_nettype none

module arpm_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start_i,
  input  wire arpm_pkg::band_t                band_i,
  input  wire logic [arpm_pkg::FULL_BITS-1:0] full_scale_i,
  input  wire logic                           take_i,
  output logic                                done_o,
  output arpm_pkg::dir_t                      dir_o,
  output logic [arpm_pkg::DUTY_BITS-1:0]      duty_o
);

  localparam int PROD_BITS = arpm_pkg::FULL_BITS + arpm_pkg::SAMPLE_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_ITER,
    ST_DONE
  } state_t;

  state_t                            state_r, state_nxt;
  arpm_pkg::dir_t                    dir_r, dir_nxt;
  logic [arpm_pkg::SAMPLE_BITS-1:0]  num_r, num_nxt, den_r, den_nxt;
  logic [arpm_pkg::SAMPLE_BITS-1:0]  rem_r, rem_nxt;
  logic [arpm_pkg::FULL_BITS-1:0]    quo_r, quo_nxt;
  logic [arpm_pkg::DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [PROD_BITS-1:0]              prod_w;
  logic [arpm_pkg::SAMPLE_BITS:0]    trial_w;
  logic                              fits_w;

  assign prod_w  = PROD_BITS'(full_scale_i) * PROD_BITS'(num_r);
  assign trial_w = {rem_r, quo_r[arpm_pkg::FULL_BITS-1]};
  assign fits_w  = (trial_w >= {1'b0, den_r});

  always_comb begin
    state_nxt = state_r;
    dir_nxt   = dir_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          dir_nxt   = band_i.dir;
          num_nxt   = band_i.num;
          den_nxt   = band_i.den;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (dir_r == arpm_pkg::DIR_DEAD) begin
          quo_nxt   = '0;
          state_nxt = ST_DONE;
        end else if ((den_r == '0) || (num_r >= den_r)) begin
          quo_nxt   = full_scale_i;
          state_nxt = ST_DONE;
        end else begin
          rem_nxt   = prod_w[PROD_BITS-1:arpm_pkg::FULL_BITS];
          quo_nxt   = prod_w[arpm_pkg::FULL_BITS-1:0];
          cnt_nxt   = arpm_pkg::DIV_CNT_BITS'(arpm_pkg::FULL_BITS - 1);
          state_nxt = ST_ITER;
        end
      end
      ST_ITER: begin
        if (fits_w) begin
          rem_nxt = arpm_pkg::SAMPLE_BITS'(trial_w - {1'b0, den_r});
        end else begin
          rem_nxt = trial_w[arpm_pkg::SAMPLE_BITS-1:0];
        end
        quo_nxt = {quo_r[arpm_pkg::FULL_BITS-2:0], fits_w};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take_i) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    dir_r <= dir_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done_o = (state_r == ST_DONE);
  assign dir_o  = dir_r;
  assign duty_o = quo_r;

endmodule

`default_nettype wire

### hw/rtl/auto_range_deadband_pwm_mapper.sv
// Top level of the auto-ranging dead-band duty mapper.
//
// The block takes one sample at a time and gives one direction/duty result
// for it. A sample passes a four-stage range and band pipeline, the prep state
// forms the product full_scale times distance, and a restoring divider then
// yields one quotient bit per cycle; that divider sets the rate. The divider
// is skipped when the sample lies in the dead band or the duty saturates. A
// new sample is taken only after the last result enters the output register;
// it waits there for the sink while the next sample is taken. Configuration
// is written through cfg_we, cfg_index and cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
`default_nettype none

module auto_range_deadband_pwm_mapper (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  arpm_in_if.sink                                 in_ch,
  arpm_out_if.source                              out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [arpm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [arpm_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  logic                           dynamic_mode_r;
  logic [arpm_pkg::HYST_BITS-1:0] hysteresis_r;
  logic [arpm_pkg::FULL_BITS-1:0] full_scale_r;
  logic                           busy_r;
  logic                           out_valid_r;
  arpm_pkg::dir_t                 out_dir_r;
  logic [arpm_pkg::DUTY_BITS-1:0] out_duty_r;
  logic                           accept_w;
  logic                           take_w;
  arpm_pkg::band_t                band_w;
  logic                           band_valid_w;
  logic                           div_done_w;
  arpm_pkg::dir_t                 div_dir_w;
  logic [arpm_pkg::DUTY_BITS-1:0] div_duty_w;

  assign accept_w = in_ch.valid && !busy_r;
  assign take_w   = div_done_w && (!out_valid_r || out_ch.ready);

  arpm_range u_range (
    .clk            (clk),
    .rst_n          (rst_n),
    .start_i        (accept_w),
    .sample_i       (in_ch.sample),
    .dynamic_mode_i (dynamic_mode_r),
    .hysteresis_i   (hysteresis_r),
    .full_scale_i   (full_scale_r),
    .band_o         (band_w),
    .band_valid_o   (band_valid_w)
  );

  arpm_div u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_i      (band_valid_w),
    .band_i       (band_w),
    .full_scale_i (full_scale_r),
    .take_i       (take_w),
    .done_o       (div_done_w),
    .dir_o        (div_dir_w),
    .duty_o       (div_duty_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dynamic_mode_r <= 1'b0;
      hysteresis_r   <= '0;
      full_scale_r   <= arpm_pkg::FULL_SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arpm_pkg::CFG_DYNAMIC: dynamic_mode_r <= cfg_data[0];
        arpm_pkg::CFG_HYST:    hysteresis_r   <= cfg_data[arpm_pkg::HYST_BITS-1:0];
        arpm_pkg::CFG_FULL:    full_scale_r   <= cfg_data[arpm_pkg::FULL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept_w) begin
        busy_r <= 1'b1;
      end else if (take_w) begin
        busy_r <= 1'b0;
      end
      if (take_w) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (take_w) begin
      out_dir_r  <= div_dir_w;
      out_duty_r <= div_duty_w;
    end
  end

  assign in_ch.ready      = !busy_r;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.direction = out_dir_r;
  assign out_ch.duty      = out_duty_r;

endmodule

`default_nettype wire

### hw/rtl/arpm_checker.sv
// Port-level checker for the dead-band mapper, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module arpm_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [arpm_pkg::DIR_BITS-1:0]  out_direction,
  input wire logic [arpm_pkg::DUTY_BITS-1:0] out_duty
);

  logic in_xfer;
  logic out_stall;
  logic out_dead;

  assign in_xfer   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_dead  = out_valid && (out_direction == arpm_pkg::DIR_DEAD);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_duty))
  `ASSERT_IMPLIES(a_dead_zero, clk, rst_n, out_dead, out_duty == '0)
  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_xfer, !in_ready)
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid && in_ready)

endmodule

bind auto_range_deadband_pwm_mapper arpm_checker u_arpm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_direction (out_ch.direction),
  .out_duty      (out_ch.duty)
);

`default_nettype wire
